/* rtl/matrix_audio_mixer_cc_gain_defines.svh */
// Assertion macros for the audio matrix mixer checker.
// Included by the checker file; no dependencies.
`ifndef MATRIX_AUDIO_MIXER_CC_GAIN_DEFINES_SVH
`define MATRIX_AUDIO_MIXER_CC_GAIN_DEFINES_SVH

// Same-cycle implication.
`define MAMCG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mixer assertion failed");

// Next-cycle implication.
`define MAMCG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mixer assertion failed");

`endif

/* rtl/mamcg_pkg.sv */
// Shared constants, types and the control-change gain table of the mixer.
// No dependencies.
`default_nettype none
package mamcg_pkg;
   localparam int MAX_INPUTS_DEF  = 8;
   localparam int MAX_OUTPUTS_DEF = 8;
   localparam int MAP_ENTRIES_DEF = 16;

   localparam int CC_FULL_SCALE = 127;
   localparam int KIND_W   = 2;
   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int CC_W     = 7;
   localparam int OCNT_W   = 4;
   localparam int PROD_W   = 40;
   localparam int ACC_W    = 43;
   localparam int DIGIT_W  = 4;
   localparam int QUO_W    = 30;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GAIN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CC     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MAP    = 2'd3;

   localparam logic [OCNT_W-1:0] OCNT_RESET = 4'd8;

   typedef struct packed {
      logic [CC_W-1:0] cc;
      logic [CH_W-1:0] in_ch;
      logic [CH_W-1:0] out_ch;
   } map_entry_type;

   typedef logic [GAIN_W-1:0] cc_lut_type [128];

   function automatic cc_lut_type build_cc_lut();
      cc_lut_type lut;
      for (int i = 0; i < 128; i++) begin
         lut[i] = GAIN_W'((i * 16384 + 63) / CC_FULL_SCALE);
      end
      return lut;
   endfunction

   localparam cc_lut_type CC_GAIN_LUT = build_cc_lut();
endpackage
`default_nettype wire

/* rtl/matrix_audio_mixer_cc_gain.sv */
// Audio matrix mixer with control-change gain mapping, top level.
// Depends on mamcg_pkg.
//
// Usage:
//  - Input transactions (req_*) carry samples, gain writes, control changes
//    and mapping additions. req_stall is high while an item is being worked.
//  - Gain, mapping and zero-entry control-change items complete in the idle
//    state; a control change walks the mapping table, one entry per cycle.
//  - A sample walks every output: per output a gain read state, a multiply
//    state worked once per 4-bit gain digit and an accumulate state, for an
//    in-range input channel.
//  - A sample with frame_end then emits one result transaction per active
//    output (csr output count, clamped to 1..MAX_OUTPUTS), one per cycle when
//    rsp_stall is low; a stalled result holds and the emit walk waits.
//  - The last result of a frame may still wait while the next item enters.
//  - Reset clears gains, accumulators, the mapping count and the output
//    register; the output count returns to 8. csr_wr_en writes the count.
`default_nettype none
module matrix_audio_mixer_cc_gain #(
   parameter int MAX_INPUTS  = mamcg_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = mamcg_pkg::MAX_OUTPUTS_DEF,
   parameter int MAP_ENTRIES = mamcg_pkg::MAP_ENTRIES_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire [mamcg_pkg::OCNT_W-1:0]           csr_wr_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire [mamcg_pkg::KIND_W-1:0]           req_kind,
   input  wire [mamcg_pkg::CH_W-1:0]             req_in_channel,
   input  wire [mamcg_pkg::CH_W-1:0]             req_out_channel,
   input  wire signed [mamcg_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  wire                                   req_frame_end,
   input  wire signed [mamcg_pkg::GAIN_W-1:0]    req_gain_value,
   input  wire [mamcg_pkg::CC_W-1:0]             req_cc_number,
   input  wire [mamcg_pkg::CC_W-1:0]             req_cc_value,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [mamcg_pkg::CH_W-1:0]            rsp_mix_channel,
   output logic signed [mamcg_pkg::SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                                  rsp_last_of_frame,
   output logic                                  rsp_clipped
);
   localparam int GN      = MAX_INPUTS * MAX_OUTPUTS;
   localparam int GADDR_W = (GN > 1) ? $clog2(GN) : 1;
   localparam int OIDX_W  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int MIDX_W  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int MCNT_W  = $clog2(MAP_ENTRIES + 1);
   localparam int SW      = mamcg_pkg::SAMPLE_W;
   localparam int GW      = mamcg_pkg::GAIN_W;
   localparam int PW      = mamcg_pkg::PROD_W;
   localparam int AW      = mamcg_pkg::ACC_W;
   localparam int DW      = mamcg_pkg::DIGIT_W;
   localparam int QW      = mamcg_pkg::QUO_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [mamcg_pkg::OCNT_W-1:0] ocount_ff;
   logic [mamcg_pkg::CH_W-1:0] ich_ff, ich_in;
   logic signed [SW-1:0] sample_ff, sample_in;
   logic fend_ff, fend_in;
   logic [mamcg_pkg::CC_W-1:0] ccn_ff, ccn_in;
   logic [GW-1:0] ccg_ff, ccg_in;
   logic [OIDX_W-1:0] oidx_ff, oidx_in;
   logic [1:0] digit_ff, digit_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [MIDX_W-1:0] scan_ff, scan_in;
   logic [MCNT_W-1:0] mcnt_ff;

   mamcg_pkg::map_entry_type map_tab [MAP_ENTRIES];
   logic [GW-1:0] gain_mem [GN];
   logic [GN-1:0] gain_vld_ff;
   logic [GW-1:0] gain_q_ff;
   logic gain_qv_ff;
   logic [AW-1:0] acc_ff [MAX_OUTPUTS];
   logic [MAX_OUTPUTS-1:0] acc_vld_ff;

   logic rsp_valid_ff;
   logic [mamcg_pkg::CH_W-1:0] rsp_ch_ff;
   logic signed [SW-1:0] rsp_smp_ff;
   logic rsp_last_ff, rsp_clip_ff;

   logic accept, ich_ok, och_ok, map_ok;
   logic [OIDX_W-1:0] last_idx;
   logic [GADDR_W-1:0] rd_addr, wr_addr;
   logic [GW-1:0] wr_data;
   logic wr_en;
   mamcg_pkg::map_entry_type scan_ent;
   logic scan_hit, scan_done;
   logic [GW-1:0] gain_cur;
   logic signed [DW:0] dig_s;
   logic signed [SW+DW:0] part;
   logic [AW-1:0] acc_cur, acc_new, emit_acc;
   logic [AW:0] rnd;
   logic [QW-1:0] quo;
   logic emit_load, acc_wr, acc_clear;
   logic [SW-1:0] sat_val;
   logic sat_clip;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ich_ok    = (32'(req_in_channel) < MAX_INPUTS);
   assign och_ok    = (32'(req_out_channel) < MAX_OUTPUTS);
   assign map_ok    = (req_cc_number != '0) && (32'(mcnt_ff) < MAP_ENTRIES) && ich_ok && och_ok;

   always_comb begin
      if (ocount_ff == '0) begin
         last_idx = '0;
      end else if (32'(ocount_ff) > MAX_OUTPUTS) begin
         last_idx = OIDX_W'(MAX_OUTPUTS - 1);
      end else begin
         last_idx = OIDX_W'(ocount_ff - 4'd1);
      end
   end

   assign scan_ent  = map_tab[scan_ff];
   assign scan_hit  = (state_ff == ST_SCAN) && (scan_ent.cc == ccn_ff);
   assign scan_done = (32'(scan_ff) + 1 >= 32'(mcnt_ff));

   always_comb begin
      if (state_ff == ST_SCAN) begin
         wr_en   = scan_hit;
         wr_addr = GADDR_W'(32'(scan_ent.in_ch) * MAX_OUTPUTS + 32'(scan_ent.out_ch));
         wr_data = ccg_ff;
      end else begin
         wr_en   = accept && (req_kind == mamcg_pkg::KIND_GAIN) && ich_ok && och_ok;
         wr_addr = GADDR_W'(32'(req_in_channel) * MAX_OUTPUTS + 32'(req_out_channel));
         wr_data = req_gain_value;
      end
   end

   assign rd_addr  = GADDR_W'(32'(ich_ff) * MAX_OUTPUTS + 32'(oidx_ff));
   assign gain_cur = gain_qv_ff ? gain_q_ff : '0;

   always_comb begin
      unique case (digit_ff)
         2'd0: dig_s = {gain_cur[GW-1], gain_cur[GW-1 -: DW]};
         2'd1: dig_s = {1'b0, gain_cur[GW-1-DW -: DW]};
         2'd2: dig_s = {1'b0, gain_cur[GW-1-2*DW -: DW]};
         default: dig_s = {1'b0, gain_cur[DW-1:0]};
      endcase
   end

   assign part    = sample_ff * dig_s;
   assign acc_cur = acc_vld_ff[oidx_ff] ? acc_ff[oidx_ff] : '0;
   assign acc_new = acc_cur + {{(AW-PW){prod_ff[PW-1]}}, prod_ff};
   assign acc_wr  = (state_ff == ST_ACC);

   assign emit_acc = acc_cur;
   assign rnd      = {emit_acc[AW-1], emit_acc} + (AW+1)'(8192);
   assign quo      = rnd[AW -: QW];

   always_comb begin
      if (!quo[QW-1] && (quo[QW-2:SW-1] != '0)) begin
         sat_val  = {1'b0, {(SW-1){1'b1}}};
         sat_clip = 1'b1;
      end else if (quo[QW-1] && (quo[QW-2:SW-1] != '1)) begin
         sat_val  = {1'b1, {(SW-1){1'b0}}};
         sat_clip = 1'b1;
      end else begin
         sat_val  = quo[SW-1:0];
         sat_clip = 1'b0;
      end
   end

   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign acc_clear = emit_load && (oidx_ff == last_idx);

   always_comb begin
      state_in  = state_ff;
      ich_in    = ich_ff;
      sample_in = sample_ff;
      fend_in   = fend_ff;
      ccn_in    = ccn_ff;
      ccg_in    = ccg_ff;
      oidx_in   = oidx_ff;
      digit_in  = digit_ff;
      prod_in   = prod_ff;
      scan_in   = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == mamcg_pkg::KIND_CC)) begin
               ccn_in  = req_cc_number;
               ccg_in  = mamcg_pkg::CC_GAIN_LUT[req_cc_value];
               scan_in = '0;
               if (mcnt_ff != '0) begin
                  state_in = ST_SCAN;
               end
            end else if (accept && (req_kind == mamcg_pkg::KIND_SAMPLE)) begin
               ich_in    = req_in_channel;
               sample_in = req_sample_value;
               fend_in   = req_frame_end;
               oidx_in   = '0;
               if (ich_ok) begin
                  state_in = ST_RD;
               end else if (req_frame_end) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_RD: begin
            digit_in = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (digit_ff == 2'd0) begin
               prod_in = PW'(part);
            end else begin
               prod_in = (prod_ff <<< DW) + PW'(part);
            end
            digit_in = digit_ff + 1'b1;
            if (digit_ff == 2'd3) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (32'(oidx_ff) == MAX_OUTPUTS - 1) begin
               oidx_in  = '0;
               state_in = fend_ff ? ST_EMIT : ST_IDLE;
            end else begin
               oidx_in  = oidx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               if (oidx_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  oidx_in = oidx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ocount_ff <= mamcg_pkg::OCNT_RESET;
         mcnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            ocount_ff <= csr_wr_data;
         end
         if (accept && (req_kind == mamcg_pkg::KIND_MAP) && map_ok) begin
            mcnt_ff <= mcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ich_ff    <= ich_in;
      sample_ff <= sample_in;
      fend_ff   <= fend_in;
      ccn_ff    <= ccn_in;
      ccg_ff    <= ccg_in;
      oidx_ff   <= oidx_in;
      digit_ff  <= digit_in;
      prod_ff   <= prod_in;
      scan_ff   <= scan_in;
   end

   always_ff @(posedge clock) begin
      if (accept && (req_kind == mamcg_pkg::KIND_MAP) && map_ok) begin
         map_tab[MIDX_W'(mcnt_ff)] <= '{cc: req_cc_number, in_ch: req_in_channel,
                                        out_ch: req_out_channel};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gain_mem[wr_addr] <= wr_data;
      end
      gain_q_ff <= gain_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_vld_ff <= '0;
         gain_qv_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            gain_vld_ff[wr_addr] <= 1'b1;
         end
         gain_qv_ff <= gain_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_wr) begin
         acc_ff[oidx_ff] <= acc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (acc_clear) begin
         acc_vld_ff <= '0;
      end else if (acc_wr) begin
         acc_vld_ff[oidx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_ch_ff   <= mamcg_pkg::CH_W'(oidx_ff);
         rsp_smp_ff  <= sat_val;
         rsp_last_ff <= (oidx_ff == last_idx);
         rsp_clip_ff <= sat_clip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mix_channel   = rsp_ch_ff;
   assign rsp_mixed_sample  = rsp_smp_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign rsp_clipped       = rsp_clip_ff;
endmodule
`default_nettype wire

/* rtl/mamcg_checker.sv */
// Port-level checker for the audio matrix mixer, bound to the top level.
// Depends on matrix_audio_mixer_cc_gain_defines.svh.
`default_nettype none
`include "matrix_audio_mixer_cc_gain_defines.svh"
module mamcg_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [2:0]  rsp_mix_channel,
   input wire [23:0] rsp_mixed_sample,
   input wire        rsp_last_of_frame,
   input wire        rsp_clipped
);
   `MAMCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_mixed_sample) && $stable(rsp_mix_channel))
   `MAMCG_ASSERT_NOW(a_clip_rail, clock, reset, rsp_valid && rsp_clipped, rsp_mixed_sample == 24'h7FFFFF || rsp_mixed_sample == 24'h800000)
   `MAMCG_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `MAMCG_ASSERT_NEXT(a_rsp_hold_flags, clock, reset, rsp_valid && rsp_stall, $stable(rsp_last_of_frame) && $stable(rsp_clipped))
endmodule

bind matrix_audio_mixer_cc_gain mamcg_checker u_mamcg_checker (.*);
`default_nettype wire
